FILE: hw/rtl/oblique_tree_ensemble_infer_top_assert.svh
// assertion macros used by the checker file oti_check
// OTI_ASSERT is gated off while rst is high, OTI_ASSERT_RST is checked on every edge
`ifndef OBLIQUE_TREE_ENSEMBLE_INFER_TOP_ASSERT_SVH
`define OBLIQUE_TREE_ENSEMBLE_INFER_TOP_ASSERT_SVH

`define OTI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define OTI_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/oti_pkg.sv
// ----------------------------------------------------------------------------
// oti_pkg
// Types, codes and sizing defaults for the oblique tree ensemble scorer.
// ----------------------------------------------------------------------------
package oti_pkg;

  // sizing defaults for the top level parameters
  localparam int MAX_TREES_DEF      = 64;
  localparam int NODES_PER_TREE_DEF = 32;
  localparam int MAX_DEPTH_DEF      = 4;
  localparam int MAX_FEATURES_DEF   = 64;

  // item action codes
  localparam logic [1:0] ACT_NODE = 2'd0;
  localparam logic [1:0] ACT_FEAT = 2'd1;
  localparam logic [1:0] ACT_EVAL = 2'd2;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SCORE = 2'd2;

  // register reset values
  localparam logic [6:0]         TREE_COUNT_RST = 7'd0;
  localparam logic [16:0]        STEP_SCALE_RST = 17'd7864;
  localparam logic [16:0]        STEP_SCALE_ONE = 17'd65536;
  localparam logic signed [31:0] BASE_SCORE_RST = 32'sd0;

  // datapath widths
  localparam int SCORE_W = 48;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = 50;
  localparam int TEST_W  = 48;

  // saturation bounds of the score in accumulator width
  localparam logic signed [ACC_W-1:0] SCORE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] SCORE_MIN = 64'shFFFF_8000_0000_0000;

  // one node store entry
  typedef struct packed {
    logic               leaf;
    logic               oblique;
    logic [5:0]         fa;
    logic [5:0]         fb;
    logic signed [31:0] value;
    logic signed [15:0] ca;
    logic signed [15:0] cb;
    logic signed [31:0] bias;
    logic [4:0]         lc;
    logic [4:0]         rc;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // sequencer to accumulator control
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

endpackage

FILE: hw/rtl/oti_item_if.sv
// ----------------------------------------------------------------------------
// oti_item_if
// Input item channel: valid/ready handshake with node, feature and eval payload.
// ----------------------------------------------------------------------------
interface oti_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [10:0]        node_addr;
  logic               leaf_flag;
  logic               split_kind;
  logic [5:0]         feature_a;
  logic [5:0]         feature_b;
  logic signed [31:0] value;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [31:0] offset;
  logic [4:0]         left_child;
  logic [4:0]         right_child;

  modport source (
    output valid, action, node_addr, leaf_flag, split_kind, feature_a, feature_b,
    output value, coef_a, coef_b, offset, left_child, right_child,
    input  ready
  );

  modport sink (
    input  valid, action, node_addr, leaf_flag, split_kind, feature_a, feature_b,
    input  value, coef_a, coef_b, offset, left_child, right_child,
    output ready
  );
endinterface

FILE: hw/rtl/oti_result_if.sv
// ----------------------------------------------------------------------------
// oti_result_if
// Result channel: valid/ready handshake carrying the score and walk error flag.
// ----------------------------------------------------------------------------
interface oti_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] score;
  logic               walk_error;

  modport source (
    output valid, score, walk_error,
    input  ready
  );

  modport sink (
    input  valid, score, walk_error,
    output ready
  );
endinterface

FILE: hw/rtl/oti_ram.sv
// ----------------------------------------------------------------------------
// oti_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module oti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/oti_split_eval.sv
// ----------------------------------------------------------------------------
// oti_split_eval
// Two stage split test: products and axis compare, then oblique sum and sign.
// ----------------------------------------------------------------------------
module oti_split_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  oti_pkg::node_t     node,
  input  logic signed [31:0] xa,
  input  logic signed [31:0] xb,
  output logic               done,
  output logic               go_left
);

  logic                             v1;
  logic                             obl;
  logic                             axis_lt;
  logic signed [oti_pkg::TEST_W-1:0] pa;
  logic signed [oti_pkg::TEST_W-1:0] pb;
  logic signed [oti_pkg::TEST_W-1:0] bias_s;
  logic signed [oti_pkg::TEST_W-1:0] sum;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      done <= v1;
    end
  end

  // stage 1: coefficient products, bias to Q18.30, axis compare
  always_ff @(posedge clk) begin
    if (start) begin
      pa      <= $signed(node.ca) * $signed(xa);
      pb      <= $signed(node.cb) * $signed(xb);
      bias_s  <= {{(oti_pkg::TEST_W - 46){node.bias[31]}}, node.bias, 14'b0};
      axis_lt <= $signed(xa) < $signed(node.value);
      obl     <= node.oblique;
    end
  end

  // stage 2: sign of the oblique sum decides
  assign sum = pa + pb + bias_s;

  always_ff @(posedge clk) begin
    if (v1) begin
      go_left <= obl ? sum[oti_pkg::TEST_W-1] : axis_lt;
    end
  end

endmodule

FILE: hw/rtl/oti_score_acc.sv
// ----------------------------------------------------------------------------
// oti_score_acc
// Exact Q32.32 score accumulator with final round and 48 bit saturation.
// ----------------------------------------------------------------------------
module oti_score_acc (
  input  logic                              clk,
  input  logic                              rst,
  input  oti_pkg::acc_ctl_t                 ctl,
  input  logic signed [31:0]                base_score,
  input  logic [16:0]                       scale,
  input  logic signed [31:0]                weight,
  output logic                              busy,
  output logic signed [oti_pkg::SCORE_W-1:0] score
);

  logic                              prod_valid;
  logic signed [oti_pkg::PROD_W-1:0] prod;
  logic signed [oti_pkg::ACC_W-1:0]  acc;
  logic signed [oti_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [oti_pkg::ACC_W-1:0]  acc_sh;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.add;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add) begin
      prod <= $signed({1'b0, scale}) * weight;
    end
  end

  // accumulate stage, cleared to base_score in Q32.32
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= {{(oti_pkg::ACC_W - 48){base_score[31]}}, base_score, 16'b0};
    end else if (prod_valid) begin
      acc <= acc + {{(oti_pkg::ACC_W - oti_pkg::PROD_W){prod[oti_pkg::PROD_W-1]}}, prod};
    end
  end

  assign busy = prod_valid;

  // round half up to Q32.16, then saturate
  assign acc_rnd = acc + 64'sd32768;
  assign acc_sh  = acc_rnd >>> 16;

  always_comb begin
    if (acc_sh > oti_pkg::SCORE_MAX) begin
      score = oti_pkg::SCORE_MAX[oti_pkg::SCORE_W-1:0];
    end else if (acc_sh < oti_pkg::SCORE_MIN) begin
      score = oti_pkg::SCORE_MIN[oti_pkg::SCORE_W-1:0];
    end else begin
      score = acc_sh[oti_pkg::SCORE_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/oblique_tree_ensemble_infer_top.sv
// ----------------------------------------------------------------------------
// oblique_tree_ensemble_infer_top
// Boosted oblique tree ensemble scorer: node store, feature store, tree walker.
// ----------------------------------------------------------------------------
// Usage
//   item_in carries one transaction per item: a node write, a feature write or
//   an evaluate request. Writes land in the node or feature RAM in the cycle
//   of the transaction and ready stays high, so writes stream one per cycle.
//   An evaluate walks trees 0 to tree_count-1 one node at a time through the
//   node RAM read port: a leaf takes a node read and a decode, a split node
//   a node read, decode, feature read and two test stages. ready is low
//   until the evaluate has finished.
//   result_out gives one transaction per evaluate: the rounded, saturated
//   Q32.16 score and walk_error. The result sits in an output register, so
//   new items are taken while it waits; a further evaluate holds in its final
//   state until the receiver has taken the previous result.
//   cfg_write/cfg_index/cfg_data update tree_count, step_scale and base_score;
//   write them only while no evaluate is in flight.
//   Reset (rst, synchronous) empties the output register, returns the
//   sequencer to idle and restores the register defaults; RAM contents are
//   undefined until written.
// ----------------------------------------------------------------------------
module oblique_tree_ensemble_infer_top #(
  parameter int MAX_TREES      = oti_pkg::MAX_TREES_DEF,
  parameter int NODES_PER_TREE = oti_pkg::NODES_PER_TREE_DEF,
  parameter int MAX_DEPTH      = oti_pkg::MAX_DEPTH_DEF,
  parameter int MAX_FEATURES   = oti_pkg::MAX_FEATURES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  oti_item_if.sink                        item_in,
  oti_result_if.source                    result_out,
  input  logic                            cfg_write,
  input  logic [oti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oti_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int STORE_DEPTH = MAX_TREES * NODES_PER_TREE;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(MAX_FEATURES);
  localparam int TW = $clog2(MAX_TREES + 1);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam logic [LW-1:0] LAST_LEVEL  = LW'(MAX_DEPTH);
  localparam logic [AW-1:0] TREE_STRIDE = AW'(NODES_PER_TREE);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NRD  = 3'd1;
  localparam logic [2:0] S_NEX  = 3'd2;
  localparam logic [2:0] S_FEV  = 3'd3;
  localparam logic [2:0] S_SPW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]         state;
  logic [6:0]         tree_count;
  logic [16:0]        step_scale;
  logic signed [31:0] base_score;
  logic [TW-1:0]      tree_idx;
  logic [AW-1:0]      tree_base;
  logic [AW-1:0]      cur_addr;
  logic [LW-1:0]      level;
  logic               walk_err;
  oti_pkg::node_t     node_q;
  logic               fa_ok;
  logic               fb_ok;
  logic               out_valid;
  logic signed [oti_pkg::SCORE_W-1:0] out_score;
  logic               out_err;

  logic               in_accept;
  logic               eval_accept;
  logic               node_we;
  logic               feat_we;
  oti_pkg::node_t     node_wdata;
  logic [oti_pkg::NODE_W-1:0] node_rdata;
  oti_pkg::node_t     node_rd;
  logic [31:0]        feat_a_rdata;
  logic [31:0]        feat_b_rdata;
  logic signed [31:0] xa;
  logic signed [31:0] xb;
  logic [TW-1:0]      n_trees;
  logic [16:0]        scale_eff;
  logic               last_tree;
  logic [4:0]         child;
  logic               child_bad;
  logic               node_re;
  logic               feat_re;
  logic               split_start;
  logic               split_done;
  logic               go_left;
  logic               tree_end;
  logic               tree_fail;
  logic               acc_busy;
  logic signed [oti_pkg::SCORE_W-1:0] acc_score;
  oti_pkg::acc_ctl_t  acc_ctl;

  // input handshake and store writes
  assign item_in.ready = (state == S_IDLE);
  assign in_accept     = item_in.valid && item_in.ready;
  assign eval_accept   = in_accept && (item_in.action == oti_pkg::ACT_EVAL);
  assign node_we       = in_accept && (item_in.action == oti_pkg::ACT_NODE)
                         && (32'(item_in.node_addr) < STORE_DEPTH);
  assign feat_we       = in_accept && (item_in.action == oti_pkg::ACT_FEAT)
                         && (32'(item_in.feature_a) < MAX_FEATURES);

  always_comb begin
    node_wdata.leaf    = item_in.leaf_flag;
    node_wdata.oblique = item_in.split_kind;
    node_wdata.fa      = item_in.feature_a;
    node_wdata.fb      = item_in.feature_b;
    node_wdata.value   = item_in.value;
    node_wdata.ca      = item_in.coef_a;
    node_wdata.cb      = item_in.coef_b;
    node_wdata.bias    = item_in.offset;
    node_wdata.lc      = item_in.left_child;
    node_wdata.rc      = item_in.right_child;
  end

  // node store
  oti_ram #(
    .WIDTH (oti_pkg::NODE_W),
    .DEPTH (STORE_DEPTH)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (AW'(item_in.node_addr)),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (cur_addr),
    .rdata (node_rdata)
  );

  assign node_rd = oti_pkg::node_t'(node_rdata);

  // feature store, two copies for the two oblique operands
  oti_ram #(
    .WIDTH (32),
    .DEPTH (MAX_FEATURES)
  ) u_feat_ram_a (
    .clk   (clk),
    .we    (feat_we),
    .waddr (FW'(item_in.feature_a)),
    .wdata (item_in.value),
    .re    (feat_re),
    .raddr (FW'(node_rd.fa)),
    .rdata (feat_a_rdata)
  );

  oti_ram #(
    .WIDTH (32),
    .DEPTH (MAX_FEATURES)
  ) u_feat_ram_b (
    .clk   (clk),
    .we    (feat_we),
    .waddr (FW'(item_in.feature_a)),
    .wdata (item_in.value),
    .re    (feat_re),
    .raddr (FW'(node_rd.fb)),
    .rdata (feat_b_rdata)
  );

  // out of range feature indexes read as zero
  assign xa = fa_ok ? $signed(feat_a_rdata) : 32'sd0;
  assign xb = fb_ok ? $signed(feat_b_rdata) : 32'sd0;

  // split test datapath
  oti_split_eval u_split_eval (
    .clk     (clk),
    .rst     (rst),
    .start   (split_start),
    .node    (node_q),
    .xa      (xa),
    .xb      (xb),
    .done    (split_done),
    .go_left (go_left)
  );

  // score accumulator
  oti_score_acc u_score_acc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (acc_ctl),
    .base_score (base_score),
    .scale      (scale_eff),
    .weight     (node_rd.value),
    .busy       (acc_busy),
    .score      (acc_score)
  );

  // clamped configuration
  assign n_trees   = (32'(tree_count) > MAX_TREES) ? TW'(MAX_TREES) : TW'(tree_count);
  assign scale_eff = (step_scale > oti_pkg::STEP_SCALE_ONE) ? oti_pkg::STEP_SCALE_ONE
                                                            : step_scale;
  assign last_tree = (TW'(tree_idx + 1'b1) >= n_trees);

  // child selection
  assign child     = go_left ? node_q.lc : node_q.rc;
  assign child_bad = (32'(child) >= NODES_PER_TREE);

  // sequencer control decode
  always_comb begin
    acc_ctl     = '0;
    node_re     = 1'b0;
    feat_re     = 1'b0;
    split_start = 1'b0;
    tree_end    = 1'b0;
    tree_fail   = 1'b0;
    unique case (state)
      S_IDLE: begin
        acc_ctl.clear = eval_accept;
      end
      S_NRD: begin
        node_re = 1'b1;
      end
      S_NEX: begin
        if (node_rd.leaf) begin
          acc_ctl.add = 1'b1;
          tree_end    = 1'b1;
        end else if (level == LAST_LEVEL) begin
          tree_end  = 1'b1;
          tree_fail = 1'b1;
        end else begin
          feat_re = 1'b1;
        end
      end
      S_FEV: begin
        split_start = 1'b1;
      end
      S_SPW: begin
        if (split_done && child_bad) begin
          tree_end  = 1'b1;
          tree_fail = 1'b1;
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      walk_err   <= 1'b0;
      tree_count <= oti_pkg::TREE_COUNT_RST;
      step_scale <= oti_pkg::STEP_SCALE_RST;
      base_score <= oti_pkg::BASE_SCORE_RST;
    end else begin
      // configuration writes
      if (cfg_write) begin
        case (cfg_index)
          oti_pkg::CFG_TREE_COUNT: tree_count <= cfg_data[6:0];
          oti_pkg::CFG_STEP_SCALE: step_scale <= cfg_data[16:0];
          oti_pkg::CFG_BASE_SCORE: base_score <= $signed(cfg_data);
          default: begin
          end
        endcase
      end

      // result transaction taken
      if (result_out.valid && result_out.ready) begin
        out_valid <= 1'b0;
      end

      if (tree_fail) begin
        walk_err <= 1'b1;
      end

      // move to the next tree or finish
      if (tree_end) begin
        if (last_tree) begin
          state <= S_FIN;
        end else begin
          tree_idx  <= tree_idx + 1'b1;
          tree_base <= tree_base + TREE_STRIDE;
          cur_addr  <= tree_base + TREE_STRIDE;
          level     <= '0;
          state     <= S_NRD;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (eval_accept) begin
            tree_idx  <= '0;
            tree_base <= '0;
            cur_addr  <= '0;
            level     <= '0;
            walk_err  <= 1'b0;
            state     <= (n_trees == '0) ? S_FIN : S_NRD;
          end
        end
        S_NRD: begin
          state <= S_NEX;
        end
        S_NEX: begin
          node_q <= node_rd;
          fa_ok  <= (32'(node_rd.fa) < MAX_FEATURES);
          fb_ok  <= (32'(node_rd.fb) < MAX_FEATURES);
          if (!tree_end) begin
            state <= S_FEV;
          end
        end
        S_FEV: begin
          state <= S_SPW;
        end
        S_SPW: begin
          if (split_done && !child_bad) begin
            level    <= level + 1'b1;
            cur_addr <= tree_base + AW'(child);
            state    <= S_NRD;
          end
        end
        S_FIN: begin
          if (!acc_busy && (!out_valid || result_out.ready)) begin
            out_valid <= 1'b1;
            out_score <= acc_score;
            out_err   <= walk_err;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign result_out.valid      = out_valid;
  assign result_out.score      = out_score;
  assign result_out.walk_error = out_err;

endmodule

FILE: hw/rtl/oti_check.sv
// ----------------------------------------------------------------------------
// oti_check
// Port level checks of the ensemble scorer, bound to the top level.
// ----------------------------------------------------------------------------
module oti_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_ready
);

`include "oblique_tree_ensemble_infer_top_assert.svh"

  // reset empties the output register
  `OTI_ASSERT_RST(a_rst_out_empty, rst |=> !out_valid, "result valid after reset")

  // a pending result holds until taken
  `OTI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")

  // an accepted evaluate transaction closes the input
  `OTI_ASSERT(a_eval_busy, in_valid && in_ready && in_action == oti_pkg::ACT_EVAL |=> !in_ready, "input open during evaluate")

  // a store write leaves the input ready for the next item
  `OTI_ASSERT(a_write_stream, in_valid && in_ready && in_action != oti_pkg::ACT_EVAL |=> in_ready, "write stalled the input")

  // a result only appears at the end of an evaluate
  `OTI_ASSERT(a_result_after_eval, $rose(out_valid) |-> !$past(in_ready), "result without evaluate")

endmodule

bind oblique_tree_ensemble_infer_top oti_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item_in.valid),
  .in_ready  (item_in.ready),
  .in_action (item_in.action),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready)
);
